// File: rtl/md5_stream_hasher_unit_macros.svh
// Assertion macros used by the MD5 stream hasher controller.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MD5_STREAM_HASHER_UNIT_MACROS_SVH
`define MD5_STREAM_HASHER_UNIT_MACROS_SVH

// Antecedent holds, so the consequent holds in the same cycle.
`define MD5SH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds, so the consequent holds in the next cycle.
`define MD5SH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/md5sh_pkg.sv
// Types, constants and round functions for the MD5 stream hasher.
// No dependencies; used by the controller, the datapath and the top level.
package md5sh_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] LAST_STEP = 6'd63;
    localparam logic [1:0] LAST_WORD = 2'd3;

    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left-rotate amount for a given step
    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        logic [4:0] amt;
        case (step[5:4])
            2'd0: begin
                case (step[1:0])
                    2'd0:    amt = 5'd7;
                    2'd1:    amt = 5'd12;
                    2'd2:    amt = 5'd17;
                    default: amt = 5'd22;
                endcase
            end
            2'd1: begin
                case (step[1:0])
                    2'd0:    amt = 5'd5;
                    2'd1:    amt = 5'd9;
                    2'd2:    amt = 5'd14;
                    default: amt = 5'd20;
                endcase
            end
            2'd2: begin
                case (step[1:0])
                    2'd0:    amt = 5'd4;
                    2'd1:    amt = 5'd11;
                    2'd2:    amt = 5'd16;
                    default: amt = 5'd23;
                endcase
            end
            default: begin
                case (step[1:0])
                    2'd0:    amt = 5'd6;
                    2'd1:    amt = 5'd10;
                    2'd2:    amt = 5'd15;
                    default: amt = 5'd21;
                endcase
            end
        endcase
        return amt;
    endfunction

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MARK = 7'b0000010,
        S_ZERO = 7'b0000100,
        S_LEN  = 7'b0001000,
        S_COMP = 7'b0010000,
        S_ADD  = 7'b0100000,
        S_FIN  = 7'b1000000
    } md5sh_state_t;

    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       wr_len;
        logic       count_byte;
        logic       step_en;
        logic [5:0] step;
        logic       add_en;
        logic       finish;
        logic [1:0] out_idx;
    } md5sh_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } md5sh_status_t;

endpackage

// File: rtl/md5sh_datapath.sv
// Datapath of the MD5 stream hasher: block buffer, bit counter, round unit,
// chaining words and digest hold registers. Depends on md5sh_pkg.
module md5sh_datapath
    import md5sh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  md5sh_cmd_t    cmd,
    output md5sh_status_t status,
    output logic [31:0]   digest_word
);

    logic [31:0] blk_reg [16];
    logic [63:0] bits_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] work_reg [4];
    logic [31:0] dig_reg [4];

    logic [31:0] f_val;
    logic [3:0]  g_idx;
    logic [31:0] pre_sum;
    logic [63:0] rot_dbl;
    logic [31:0] new_b;

    assign status.pos  = bits_reg[8:3];
    assign digest_word = dig_reg[cmd.out_idx];

    // One MD5 step: a, b, c, d live in work_reg[0..3]
    always_comb
    begin
        case (cmd.step[5:4])
            2'd0: begin
                f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
                g_idx = cmd.step[3:0];
            end
            2'd1: begin
                f_val = (work_reg[1] & work_reg[3]) | (work_reg[2] & ~work_reg[3]);
                g_idx = 4'(cmd.step[3:0] * 4'd5 + 4'd1);
            end
            2'd2: begin
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                g_idx = 4'(cmd.step[3:0] * 4'd3 + 4'd5);
            end
            default: begin
                f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
                g_idx = 4'(cmd.step[3:0] * 4'd7);
            end
        endcase
        pre_sum = work_reg[0] + f_val + K_TABLE[cmd.step] + blk_reg[g_idx];
        rot_dbl = {pre_sum, pre_sum} << rot_amount(cmd.step);
        new_b   = work_reg[1] + rot_dbl[63:32];
    end

    // Block buffer holds bytes little-endian within each word
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            case (cmd.wr_addr[1:0])
                2'd0:    blk_reg[cmd.wr_addr[5:2]][7:0]   <= cmd.wr_data;
                2'd1:    blk_reg[cmd.wr_addr[5:2]][15:8]  <= cmd.wr_data;
                2'd2:    blk_reg[cmd.wr_addr[5:2]][23:16] <= cmd.wr_data;
                default: blk_reg[cmd.wr_addr[5:2]][31:24] <= cmd.wr_data;
            endcase
        end
        if (cmd.wr_len)
        begin
            blk_reg[14] <= bits_reg[31:0];
            blk_reg[15] <= bits_reg[63:32];
        end
        if (cmd.finish)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dig_reg[i] <= chain_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg     <= '0;
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
            work_reg[0]  <= IV_A;
            work_reg[1]  <= IV_B;
            work_reg[2]  <= IV_C;
            work_reg[3]  <= IV_D;
        end
        else
        begin
            if (cmd.count_byte)
            begin
                bits_reg <= bits_reg + 64'd8;
            end
            if (cmd.step_en)
            begin
                work_reg[0] <= work_reg[3];
                work_reg[1] <= new_b;
                work_reg[2] <= work_reg[1];
                work_reg[3] <= work_reg[2];
            end
            // Keep the working words equal to the chain between blocks
            if (cmd.add_en)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                    work_reg[i]  <= chain_reg[i] + work_reg[i];
                end
            end
            if (cmd.finish)
            begin
                bits_reg     <= '0;
                chain_reg[0] <= IV_A;
                chain_reg[1] <= IV_B;
                chain_reg[2] <= IV_C;
                chain_reg[3] <= IV_D;
                work_reg[0]  <= IV_A;
                work_reg[1]  <= IV_B;
                work_reg[2]  <= IV_C;
                work_reg[3]  <= IV_D;
            end
        end
    end

endmodule

// File: rtl/md5sh_ctrl.sv
// Controller of the MD5 stream hasher: request intake, padding sequence,
// round counter and digest output counter. Depends on md5sh_pkg and the macros.
`include "md5_stream_hasher_unit_macros.svh"

module md5sh_ctrl
    import md5sh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_present,
    input  logic          in_end,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_idx,
    output logic          out_last,
    output md5sh_cmd_t    cmd,
    input  md5sh_status_t status
);

    md5sh_state_t state_reg, state_next;
    md5sh_state_t ret_reg, ret_next;
    logic [5:0]   step_reg, step_next;
    logic [5:0]   ptr_reg, ptr_next;
    logic         tail_long_reg, tail_long_next;
    logic         busy_reg, busy_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         in_acc;
    logic         out_acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = busy_reg;
    assign out_acc   = busy_reg && out_ready;
    assign out_idx   = cnt_reg;
    assign out_last  = (cnt_reg == LAST_WORD);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        step_next      = step_reg;
        ptr_next       = ptr_reg;
        tail_long_next = tail_long_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.step       = step_reg;
        cmd.out_idx    = cnt_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_acc)
                begin
                    if (in_present)
                    begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_addr    = status.pos;
                        cmd.wr_data    = in_byte;
                        cmd.count_byte = 1'b1;
                    end
                    if (in_present && status.pos == LAST_POS)
                    begin
                        state_next = S_COMP;
                        ret_next   = in_end ? S_MARK : S_IDLE;
                    end
                    else if (in_end)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_MARK: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_addr    = status.pos;
                cmd.wr_data    = PAD_MARK;
                ptr_next       = status.pos + 6'd1;
                tail_long_next = status.pos inside {[6'd56:6'd62]};
                if (status.pos == LAST_POS)
                begin
                    state_next = S_COMP;
                    ret_next   = S_ZERO;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO: begin
                if (ptr_reg == LEN_POS && !tail_long_reg)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = ptr_reg;
                    cmd.wr_data = 8'h00;
                    ptr_next    = ptr_reg + 6'd1;
                    // Tail overran the length field: flush and start a zero block
                    if (ptr_reg == LAST_POS)
                    begin
                        tail_long_next = 1'b0;
                        state_next     = S_COMP;
                        ret_next       = S_ZERO;
                    end
                end
            end
            S_LEN: begin
                cmd.wr_len = 1'b1;
                state_next = S_COMP;
                ret_next   = S_FIN;
            end
            S_COMP: begin
                cmd.step_en = 1'b1;
                step_next   = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                cmd.add_en = 1'b1;
                state_next = ret_reg;
            end
            S_FIN: begin
                // Hold until the previous digest has been drained
                if (!busy_reg)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_acc)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == LAST_WORD)
            begin
                busy_next = 1'b0;
            end
        end
        if (cmd.finish)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            step_reg      <= '0;
            ptr_reg       <= '0;
            tail_long_reg <= 1'b0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            step_reg      <= step_next;
            ptr_reg       <= ptr_next;
            tail_long_reg <= tail_long_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
        end
    end

    `MD5SH_ASSERT_IMPL(a_no_write_in_round, cmd.step_en, !cmd.wr_en && !cmd.wr_len, "buffer written during compression")
    `MD5SH_ASSERT_NEXT(a_round_ends, (state_reg == S_COMP) && (step_reg == LAST_STEP), state_reg == S_ADD, "compression did not end after the last step")
    `MD5SH_ASSERT_NEXT(a_drain_ends, out_acc && (cnt_reg == LAST_WORD), !busy_reg, "digest still pending after last word")
    `MD5SH_ASSERT_IMPL(a_len_position, state_reg == S_LEN, ptr_reg == LEN_POS, "length written at wrong position")

endmodule

// File: rtl/md5_stream_hasher_unit.sv
// MD5 stream hasher, top level: at most one byte per request in, four digest words out.
// Requests are taken while the controller is idle; every 64th byte stalls intake for
// the 64 shared round-unit steps plus the chain add. Closing a message writes the 0x80
// mark and the zero bytes, takes a step to reach the length field, writes the length
// and runs the last block, plus one more block when the tail reaches byte 56 or beyond,
// then latches the digest, which waits until the previous digest has fully drained.
// The digest is then drained as four words (A to D) while the next message is taken
// in. Depends on md5sh_pkg.
module md5_stream_hasher_unit
    import md5sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);

    md5sh_cmd_t    cmd;
    md5sh_status_t status;

    md5sh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_present (s_axis_tuser),
        .in_end     (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_idx    (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .cmd        (cmd),
        .status     (status)
    );

    md5sh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .digest_word (m_axis_tdata)
    );

endmodule

// File: tb/sv/md5_stream_hasher_unit_test.sv
// Self-checking bench for md5_stream_hasher_unit: byte requests in, digest words out.
// Expected digests come from a behavioural MD5 kept inside the bench, plus a few
// known digests typed into the directed table. Needs only the RTL and md5sh_pkg.
module md5_stream_hasher_unit_test;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_beat_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         close;
        logic         typed;
        logic [127:0] digest;
    } stim_row_t;

    // Digests packed as {A, B, C, D}, each word holding its bytes little-endian
    localparam logic [127:0] EMPTY_DIGEST =
        128'hd98c1dd4_04b2008f_980980e9_7e42f8ec;
    localparam logic [127:0] ABC_DIGEST =
        128'h98500190_b04fd23c_7d3f96d6_727fe128;

    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROUND_SHIFT [16] = '{
        7, 12, 17, 22,  5, 9, 14, 20,  4, 11, 16, 23,  6, 10, 15, 21
    };

    localparam int DIRECTED_COUNT = 16;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        {8'hFF, 1'b0, 1'b0, 1'b0, 128'h0},          // ignored request
        {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message straight after reset
        {8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'h62, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},      // byte and end together
        {8'h00, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'hFF, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'hA5, 1'b0, 1'b0, 1'b0, 128'h0},          // ignored mid-message
        {8'h5A, 1'b0, 1'b1, 1'b0, 128'h0},          // end without a byte
        {8'hFF, 1'b1, 1'b1, 1'b0, 128'h0},
        {8'h00, 1'b1, 1'b1, 1'b0, 128'h0},
        {8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty again, chain back at start
        {8'h80, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'h7F, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'h01, 1'b1, 1'b0, 1'b0, 128'h0},
        {8'hFE, 1'b1, 1'b1, 1'b0, 128'h0}
    };

    localparam int SRC_IDLE [3]  = '{31, 80, 0};
    localparam int SINK_IDLE [3] = '{80, 31, 0};
    // Opening message of each phase: tail lands past the length field
    localparam int OPENING_LEN [3] = '{56, 63, 120};
    localparam int PHASE_ITEMS = 60;
    localparam int LONG_STALL_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] byte_present
    logic        s_axis_tlast = 1'b0;    // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [1:0]  m_axis_tuser;           // [1:0] word_index
    logic        m_axis_tlast;           // last_word

    // Behavioural MD5 state
    logic [31:0] chain_acc [4] = CHAIN_INIT;
    logic [7:0]  block_buf [64];
    logic [63:0] msg_len_bits = 64'd0;

    digest_beat_t digest_beats_due [$];
    int err_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    logic long_stall_req = 1'b0;
    int stall_left = 0;

    md5_stream_hasher_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void md5_compress();
        logic [31:0] w [16];
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] f;
        logic [31:0] t;
        logic [31:0] sum;
        int i;
        int g;
        int r;
        int s;
        for (i = 0; i < 16; i++)
            w[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
        a = chain_acc[0];
        b = chain_acc[1];
        c = chain_acc[2];
        d = chain_acc[3];
        for (i = 0; i < 64; i++)
        begin
            r = i / 16;
            case (r)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            sum = a + f + ROUND_K[i] + w[g];
            s = ROUND_SHIFT[r * 4 + i % 4];
            t = d;
            d = c;
            c = b;
            b = b + ((sum << s) | (sum >> (32 - s)));
            a = t;
        end
        chain_acc[0] += a;
        chain_acc[1] += b;
        chain_acc[2] += c;
        chain_acc[3] += d;
    endfunction

    // Take one request into the behavioural hash; done marks a finished digest
    function automatic void fold_request(input logic [7:0] data, input logic present,
                                         input logic close, output logic done,
                                         output logic [127:0] digest);
        logic [5:0]  pos;
        logic [63:0] len;
        int i;
        done = 1'b0;
        digest = '0;
        if (present)
        begin
            pos = msg_len_bits[8:3];
            block_buf[pos] = data;
            msg_len_bits += 64'd8;
            if (pos == 6'd63)
                md5_compress();
        end
        if (close)
        begin
            len = msg_len_bits;
            pos = len[8:3];
            block_buf[pos] = 8'h80;
            for (i = pos + 1; i < 64; i++)
                block_buf[i] = 8'h00;
            // no room left for the length: flush and carry it in a fresh block
            if (pos >= 6'd56)
            begin
                md5_compress();
                for (i = 0; i < 56; i++)
                    block_buf[i] = 8'h00;
            end
            for (i = 0; i < 8; i++)
                block_buf[56 + i] = len[8*i +: 8];
            md5_compress();
            digest = {chain_acc[0], chain_acc[1], chain_acc[2], chain_acc[3]};
            chain_acc = CHAIN_INIT;
            msg_len_bits = 64'd0;
            done = 1'b1;
        end
    endfunction

    // Offer one request, wait for its handshake, then book any digest it finishes
    task automatic offer_request(input logic [7:0] data, input logic present,
                                 input logic close, input logic typed,
                                 input logic [127:0] typed_digest);
        int gap;
        int k;
        logic done;
        logic [127:0] digest;
        digest_beat_t beat;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= close;
        // sample at the falling edge, where nothing is in motion
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        fold_request(data, present, close, done, digest);
        if (done)
        begin
            if (typed)
                digest = typed_digest;
            for (k = 0; k < 4; k++)
            begin
                beat = {digest[127 - 32*k -: 32], k[1:0], k == 3};
                digest_beats_due.push_back(beat);
            end
        end
    endtask

    // One well-formed message with random content, salted with ignored requests
    task automatic send_message(input int len, output int sent);
        logic split;
        int i;
        split = (len == 0) || ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            offer_request(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split,
                          1'b0, '0);
        end
        if (split)
            offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
        sent = len + int'(split);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (long_stall_req)
        begin
            long_stall_req = 1'b0;
            stall_left = LONG_STALL_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(negedge clk)
    begin : digest_watch
        digest_beat_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_beats_due.size() == 0)
            begin
                $error("digest_word: none expected, actual %h", m_axis_tdata);
                err_count++;
            end
            else
            begin
                due = digest_beats_due.pop_front();
                if (m_axis_tdata !== due.word)
                begin
                    $error("digest_word: expected %h, actual %h", due.word, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tuser !== due.index)
                begin
                    $error("word_index: expected %0d, actual %0d", due.index, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tlast !== due.last)
                begin
                    $error("last_word: expected %b, actual %b", due.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int row;
        int phase;
        int items;
        int sent;
        int len;
        int n;
        src_idle_pct = SRC_IDLE[0];
        sink_idle_pct = SINK_IDLE[0];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_COUNT; row++)
            offer_request(DIRECTED_ROWS[row].data, DIRECTED_ROWS[row].present,
                          DIRECTED_ROWS[row].close, DIRECTED_ROWS[row].typed,
                          DIRECTED_ROWS[row].digest);

        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = SRC_IDLE[phase];
            sink_idle_pct = SINK_IDLE[phase];
            if (phase == 2)
            begin
                // hold the output off and feed twelve short messages, so that intake stalls
                long_stall_req = 1'b1;
                for (n = 0; n < 12; n++)
                    send_message($urandom_range(1, 3), sent);
                // pause until every digest has drained
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (digest_beats_due.size() != 0);
            end
            send_message(OPENING_LEN[phase], items);
            while (items < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 99) < 20) ? $urandom_range(50, 70)
                                                   : $urandom_range(0, 16);
                send_message(len, sent);
                items += sent;
            end
        end

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (digest_beats_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("md5_stream_hasher_unit_test OK");
        else
            $display("md5_stream_hasher_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("md5_stream_hasher_unit_test NOT OK");
        $finish;
    end

endmodule
